FILE: rtl/crts_pkg.sv
// ----------------------------------------------------------------------------
// crts_pkg
// Shared types and constants of the track spline sampler.
// ----------------------------------------------------------------------------
package crts_pkg;

  localparam int CHANNELS   = 7;
  localparam int CH_W       = 16;
  localparam int POS_W      = 24;
  localparam int FRAC_W     = 12;
  localparam int T_W        = FRAC_W + 1;
  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  // node counts and indices up to the largest supported table of 1024 nodes
  localparam int N_W        = 11;
  localparam int ADDR_MAX_W = 10;

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_W;
  localparam logic [CH_W-1:0] SAT_MAX = {1'b0, {(CH_W-1){1'b1}}};
  localparam logic [CH_W-1:0] SAT_MIN = {1'b1, {(CH_W-1){1'b0}}};

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_COUNT = 1'b0,
    REG_LOOP_MODE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_WRITE,
    KIND_ZERO,
    KIND_SAMPLE
  } kind_t;

  typedef logic [CH_W-1:0] chan_t;
  typedef chan_t [CHANNELS-1:0] node_t;

  // one word of the queue between front and back
  typedef struct packed {
    kind_t                 kind;
    logic [ADDR_MAX_W-1:0] a0;
    logic [ADDR_MAX_W-1:0] a1;
    logic [ADDR_MAX_W-1:0] a2;
    logic [ADDR_MAX_W-1:0] a3;
    logic [T_W-1:0]        t;
    node_t                 data;
  } entry_t;

endpackage

FILE: rtl/crts_ram.sv
// ----------------------------------------------------------------------------
// crts_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module crts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/crts_fifo.sv
// ----------------------------------------------------------------------------
// crts_fifo
// Small register queue; depth is a power of two.
// ----------------------------------------------------------------------------
module crts_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW:0]      wr_r;
  logic [PW:0]      rd_r;
  logic             full;

  assign empty = (wr_r == rd_r);
  assign full  = (wr_r[PW] != rd_r[PW]) && (wr_r[PW-1:0] == rd_r[PW-1:0]);
  assign dout  = mem[rd_r[PW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + (PW+1)'(1);
      end
      if (pop) begin
        rd_r <= rd_r + (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r[PW-1:0]] <= din;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("word pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("word popped from empty queue");
`endif

endmodule

FILE: rtl/crts_front.sv
// ----------------------------------------------------------------------------
// crts_front
// Accepts words, classifies them and works out the four node indices and
// the segment fraction; feeds the queue toward the back.
// ----------------------------------------------------------------------------
module crts_front #(
  parameter int MAX_NODES = 64,
  parameter int QDEPTH    = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               req_type,
  input  logic [crts_pkg::IDX_W-1:0]         node_index,
  input  crts_pkg::node_t                    node_data,
  input  logic [crts_pkg::POS_W-1:0]         position,
  input  logic [crts_pkg::CNT_W-1:0]         node_count,
  input  logic                               loop_mode,
  output logic                               q_push,
  output crts_pkg::entry_t                   q_entry,
  input  logic                               q_pop
);

  localparam int NW = crts_pkg::N_W;
  localparam int CW = $clog2(QDEPTH + 1);

  typedef struct packed {
    crts_pkg::kind_t                       kind;
    logic                                  loop;
    logic [NW-1:0]                         n;
    logic [NW-1:0]                         ip;
    logic [crts_pkg::T_W-1:0]              t;
    logic                                  neg;
    logic [NW-1:0]                         r;
    logic [crts_pkg::ADDR_MAX_W-1:0]       waddr;
    crts_pkg::node_t                       data;
  } fstage_t;

  function automatic logic [NW-1:0] mod_step(input logic [NW-1:0] r,
                                             input logic [NW-1:0] n, input int k);
    logic [2*NW-1:0] d;
    begin
      d = {NW'(0), n} << k;
      if ({NW'(0), r} >= d) begin
        r = r - d[NW-1:0];
      end
      return r;
    end
  endfunction

  logic          accept;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [4:1]    vld_r;
  fstage_t       st0;
  fstage_t       s1_r, s2_r, s3_r, s4_r;
  fstage_t       s2_nxt, s3_nxt, s4_nxt;
  logic [NW-1:0] r1_w, r2_w, r3_w;
  logic [NW-1:0] n_ext, n_sel, ipos_u;
  logic [NW-1:0] i0, i1, i2, i3, ipm, sum2;

  assign full   = (cnt_r == CW'(QDEPTH));
  assign accept = push && !full;
  assign cnt_nxt = cnt_r + CW'(accept) - CW'(q_pop);

  // classify and split the position
  always_comb begin
    n_ext  = {(NW-crts_pkg::CNT_W)'(0), node_count};
    n_sel  = (n_ext > NW'(MAX_NODES)) ? NW'(MAX_NODES) : n_ext;
    ipos_u = position[crts_pkg::POS_W-2:crts_pkg::FRAC_W];
    st0.loop  = loop_mode;
    st0.n     = n_sel;
    st0.neg   = position[crts_pkg::POS_W-1];
    st0.r     = st0.neg ? ~ipos_u : ipos_u;
    st0.waddr = {(crts_pkg::ADDR_MAX_W-crts_pkg::IDX_W)'(0), node_index};
    st0.data  = node_data;
    st0.ip    = '0;
    st0.t     = {1'b0, position[crts_pkg::FRAC_W-1:0]};
    if (!loop_mode) begin
      if (st0.neg) begin
        st0.t = '0;
      end else if (ipos_u >= n_sel - NW'(1)) begin
        st0.ip = n_sel - NW'(2);
        st0.t  = crts_pkg::T_ONE;
      end else begin
        st0.ip = ipos_u;
      end
    end
    if (req_type == crts_pkg::REQ_WRITE) begin
      st0.kind = ({(NW-crts_pkg::IDX_W)'(0), node_index} < NW'(MAX_NODES)) ?
                 crts_pkg::KIND_WRITE : crts_pkg::KIND_NOP;
    end else if (n_sel == '0) begin
      st0.kind = crts_pkg::KIND_ZERO;
    end else begin
      st0.kind = crts_pkg::KIND_SAMPLE;
    end
  end

  // loop position modulo node count, a few restoring steps per stage
  always_comb begin
    r1_w = s1_r.r;
    for (int k = 10; k >= 7; k--) begin
      r1_w = mod_step(r1_w, s1_r.n, k);
    end
    r2_w = s2_r.r;
    for (int k = 6; k >= 3; k--) begin
      r2_w = mod_step(r2_w, s2_r.n, k);
    end
    r3_w = s3_r.r;
    for (int k = 2; k >= 0; k--) begin
      r3_w = mod_step(r3_w, s3_r.n, k);
    end
    s2_nxt   = s1_r;
    s2_nxt.r = r1_w;
    s3_nxt   = s2_r;
    s3_nxt.r = r2_w;
    s4_nxt   = s3_r;
    s4_nxt.r = r3_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
    end else begin
      vld_r <= {vld_r[3:1], accept};
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= st0;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
    s4_r <= s4_nxt;
  end

  // neighbour indices
  always_comb begin
    ipm  = s4_r.neg ? (s4_r.n - NW'(1) - s4_r.r) : s4_r.r;
    sum2 = '0;
    if (s4_r.n == NW'(1)) begin
      i0 = '0;
      i1 = '0;
      i2 = '0;
      i3 = '0;
    end else if (s4_r.loop) begin
      sum2 = ipm + NW'(2);
      i0 = (ipm == '0) ? s4_r.n - NW'(1) : ipm - NW'(1);
      i1 = ipm;
      i2 = (ipm + NW'(1) == s4_r.n) ? '0 : ipm + NW'(1);
      i3 = (sum2 >= s4_r.n) ? sum2 - s4_r.n : sum2;
    end else begin
      sum2 = s4_r.ip + NW'(2);
      i0 = (s4_r.ip == '0) ? '0 : s4_r.ip - NW'(1);
      i1 = s4_r.ip;
      i2 = s4_r.ip + NW'(1);
      i3 = (sum2 > s4_r.n - NW'(1)) ? s4_r.n - NW'(1) : sum2;
    end
  end

  always_comb begin
    q_push       = vld_r[4];
    q_entry.kind = s4_r.kind;
    q_entry.a0   = crts_pkg::ADDR_MAX_W'(i0);
    q_entry.a1   = (s4_r.kind == crts_pkg::KIND_WRITE) ? s4_r.waddr :
                   crts_pkg::ADDR_MAX_W'(i1);
    q_entry.a2   = crts_pkg::ADDR_MAX_W'(i2);
    q_entry.a3   = crts_pkg::ADDR_MAX_W'(i3);
    q_entry.t    = (s4_r.n == NW'(1)) ? '0 : s4_r.t;
    q_entry.data = s4_r.data;
  end

`ifndef ASSERT_OFF
  a_pop_counted: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> cnt_r != '0)
    else $error("queue word popped that front never counted");
`endif

endmodule

FILE: rtl/crts_back.sv
// ----------------------------------------------------------------------------
// crts_back
// Performs node writes and spline evaluation: node table lookup, then a
// Horner chain over seven channel lanes with saturation.
// ----------------------------------------------------------------------------
module crts_back #(
  parameter int MAX_NODES = 64,
  parameter int ODEPTH    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  crts_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             res_push,
  output crts_pkg::node_t  res_data,
  input  logic             res_pop
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(ODEPTH + 1);
  localparam int NB = $bits(crts_pkg::node_t);
  localparam int CH = crts_pkg::CHANNELS;

  logic          reserve, ram_we;
  logic [CW-1:0] cred_r;
  logic [NB-1:0] rd0, rd1, rd2, rd3;
  crts_pkg::node_t d0, d1, d2, d3;
  logic [5:1]    vld_r;
  logic          b1_zero_r;
  logic [crts_pkg::T_W-1:0] b1_t_r, b2_t_r, b3_t_r, b4_t_r;
  logic signed [crts_pkg::T_W:0] ts2, ts3, ts4;

  logic signed [15:0] p0_w [CH];
  logic signed [15:0] p1_w [CH];
  logic signed [15:0] p2_w [CH];
  logic signed [15:0] p3_w [CH];
  logic signed [16:0] a_nxt [CH];
  logic signed [19:0] b_nxt [CH];
  logic signed [18:0] c_nxt [CH];
  logic signed [16:0] b2_a_r [CH];
  logic signed [19:0] b2_b_r [CH];
  logic signed [18:0] b2_c_r [CH];
  logic signed [15:0] b2_p1_r [CH];
  logic signed [32:0] m1_w [CH];
  logic signed [33:0] h1_nxt [CH];
  logic signed [33:0] b3_h1_r [CH];
  logic signed [16:0] b3_a_r [CH];
  logic signed [15:0] b3_p1_r [CH];
  logic signed [47:0] h2_nxt [CH];
  logic signed [47:0] b4_h2_r [CH];
  logic signed [15:0] b4_p1_r [CH];
  logic signed [61:0] h3_nxt [CH];
  logic signed [61:0] b5_h3_r [CH];
  logic signed [15:0] b5_p1_r [CH];
  logic signed [63:0] sum_w [CH];

  assign reserve = (q_entry.kind == crts_pkg::KIND_ZERO) ||
                   (q_entry.kind == crts_pkg::KIND_SAMPLE);
  assign q_pop   = !q_empty && (!reserve || (cred_r < CW'(ODEPTH)));
  assign ram_we  = q_pop && (q_entry.kind == crts_pkg::KIND_WRITE);

  crts_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_ram_lo (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (q_entry.a1[AW-1:0]),
    .wdata   (q_entry.data),
    .raddr_a (q_entry.a0[AW-1:0]),
    .raddr_b (q_entry.a1[AW-1:0]),
    .rdata_a (rd0),
    .rdata_b (rd1)
  );

  crts_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_ram_hi (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (q_entry.a1[AW-1:0]),
    .wdata   (q_entry.data),
    .raddr_a (q_entry.a2[AW-1:0]),
    .raddr_b (q_entry.a3[AW-1:0]),
    .rdata_a (rd2),
    .rdata_b (rd3)
  );

  assign d0 = rd0;
  assign d1 = rd1;
  assign d2 = rd2;
  assign d3 = rd3;
  assign ts2 = $signed({1'b0, b2_t_r});
  assign ts3 = $signed({1'b0, b3_t_r});
  assign ts4 = $signed({1'b0, b4_t_r});

  always_comb begin
    for (int k = 0; k < CH; k++) begin
      p0_w[k] = b1_zero_r ? '0 : $signed(d0[k]);
      p1_w[k] = b1_zero_r ? '0 : $signed(d1[k]);
      p2_w[k] = b1_zero_r ? '0 : $signed(d2[k]);
      p3_w[k] = b1_zero_r ? '0 : $signed(d3[k]);
      a_nxt[k] = 17'(p2_w[k]) - 17'(p0_w[k]);
      b_nxt[k] = (20'(p0_w[k]) <<< 1) - (20'(p1_w[k]) <<< 2) - 20'(p1_w[k])
               + (20'(p2_w[k]) <<< 2) - 20'(p3_w[k]);
      c_nxt[k] = -19'(p0_w[k]) + (19'(p1_w[k]) <<< 1) + 19'(p1_w[k])
               - (19'(p2_w[k]) <<< 1) - 19'(p2_w[k]) + 19'(p3_w[k]);
      m1_w[k]   = b2_c_r[k] * ts2;
      h1_nxt[k] = 34'(m1_w[k]) + (34'(b2_b_r[k]) <<< 12);
      h2_nxt[k] = b3_h1_r[k] * ts3 + (48'(b3_a_r[k]) <<< 24);
      h3_nxt[k] = b4_h2_r[k] * ts4;
      sum_w[k]  = 64'(b5_h3_r[k]) + (64'(b5_p1_r[k]) <<< 37) + (64'sd1 <<< 36);
      if ((&sum_w[k][63:52]) || !(|sum_w[k][63:52])) begin
        res_data[k] = sum_w[k][52:37];
      end else begin
        res_data[k] = sum_w[k][63] ? crts_pkg::SAT_MIN : crts_pkg::SAT_MAX;
      end
    end
  end

  assign res_push = vld_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      cred_r <= '0;
    end else begin
      vld_r  <= {vld_r[4:1], q_pop && reserve};
      cred_r <= cred_r + CW'(q_pop && reserve) - CW'(res_pop);
    end
  end

  always_ff @(posedge clk) begin
    b1_zero_r <= (q_entry.kind == crts_pkg::KIND_ZERO);
    b1_t_r    <= q_entry.t;
    b2_t_r    <= b1_t_r;
    b3_t_r    <= b2_t_r;
    b4_t_r    <= b3_t_r;
    for (int k = 0; k < CH; k++) begin
      b2_a_r[k]  <= a_nxt[k];
      b2_b_r[k]  <= b_nxt[k];
      b2_c_r[k]  <= c_nxt[k];
      b2_p1_r[k] <= p1_w[k];
      b3_h1_r[k] <= h1_nxt[k];
      b3_a_r[k]  <= b2_a_r[k];
      b3_p1_r[k] <= b2_p1_r[k];
      b4_h2_r[k] <= h2_nxt[k];
      b4_p1_r[k] <= b3_p1_r[k];
      b5_h3_r[k] <= h3_nxt[k];
      b5_p1_r[k] <= b4_p1_r[k];
    end
  end

`ifndef ASSERT_OFF
  a_take_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    res_pop |-> cred_r != '0)
    else $error("result word taken without a reserved slot");
`endif

endmodule

FILE: rtl/catmull_rom_track_sampler.sv
// ----------------------------------------------------------------------------
// catmull_rom_track_sampler
// Node table with Catmull-Rom sampling of seven track channels.
// Throughput: one word per cycle, writes and samples alike, while full is low
// and, for samples, an output queue slot is free; the four table reads per
// sample are served by two dual read port RAMs.
// Reset: clears config registers, valid bits and queue pointers; table contents stay undefined.
// ----------------------------------------------------------------------------
module catmull_rom_track_sampler #(
  parameter int MAX_NODES = 64,
  parameter int QDEPTH    = 8,
  parameter int ODEPTH    = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_req_type,
  input  logic [crts_pkg::IDX_W-1:0]         in_node_index,
  input  logic signed [15:0]                 in_node_x,
  input  logic signed [15:0]                 in_node_y,
  input  logic signed [15:0]                 in_node_z,
  input  logic signed [15:0]                 in_node_width,
  input  logic signed [15:0]                 in_node_wall,
  input  logic signed [15:0]                 in_node_ceil,
  input  logic signed [15:0]                 in_node_lava,
  input  logic signed [crts_pkg::POS_W-1:0]  in_position,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [15:0]                 out_x,
  output logic signed [15:0]                 out_y,
  output logic signed [15:0]                 out_z,
  output logic signed [15:0]                 out_width,
  output logic signed [15:0]                 out_wall,
  output logic signed [15:0]                 out_ceil,
  output logic signed [15:0]                 out_lava,
  input  logic                               cfg_wr_en,
  input  logic [crts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crts_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [crts_pkg::CNT_W-1:0] node_count_r;
  logic                       loop_mode_r;
  crts_pkg::node_t            in_node;
  crts_pkg::node_t            res_data;
  crts_pkg::node_t            out_word;
  crts_pkg::entry_t           q_in, q_out;
  logic                       q_push, q_pop, q_empty, res_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      loop_mode_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (crts_pkg::cfg_reg_t'(cfg_index))
        crts_pkg::REG_NODE_COUNT: node_count_r <= cfg_data[crts_pkg::CNT_W-1:0];
        crts_pkg::REG_LOOP_MODE:  loop_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_node[0] = in_node_x;
    in_node[1] = in_node_y;
    in_node[2] = in_node_z;
    in_node[3] = in_node_width;
    in_node[4] = in_node_wall;
    in_node[5] = in_node_ceil;
    in_node[6] = in_node_lava;
  end

  crts_front #(.MAX_NODES(MAX_NODES), .QDEPTH(QDEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .req_type   (in_req_type),
    .node_index (in_node_index),
    .node_data  (in_node),
    .position   (in_position),
    .node_count (node_count_r),
    .loop_mode  (loop_mode_r),
    .q_push     (q_push),
    .q_entry    (q_in),
    .q_pop      (q_pop)
  );

  crts_fifo #(.WIDTH($bits(crts_pkg::entry_t)), .DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  crts_back #(.MAX_NODES(MAX_NODES), .ODEPTH(ODEPTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_entry  (q_out),
    .q_pop    (q_pop),
    .res_push (res_push),
    .res_data (res_data),
    .res_pop  (pop && !empty)
  );

  crts_fifo #(.WIDTH($bits(crts_pkg::node_t)), .DEPTH(ODEPTH)) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_data),
    .pop   (pop && !empty),
    .dout  (out_word),
    .empty (empty)
  );

  assign out_x     = out_word[0];
  assign out_y     = out_word[1];
  assign out_z     = out_word[2];
  assign out_width = out_word[3];
  assign out_wall  = out_word[4];
  assign out_ceil  = out_word[5];
  assign out_lava  = out_word[6];

endmodule
